// ===== src/rate_monotonic_task_scheduler_defines.svh =====
// rate_monotonic_task_scheduler_defines.svh: assertion macros for the scheduler checker
// no dependencies; taken in by the checker with `include
`ifndef RATE_MONOTONIC_TASK_SCHEDULER_DEFINES_SVH
`define RATE_MONOTONIC_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RMS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rms_pkg.sv =====
// rms_pkg.sv: types, codes and constants of the rate monotonic task scheduler
// no dependencies; used by rms_div, rms_datapath, rms_ctrl and the top level
package rms_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;
   localparam int OP_W      = 2;
   localparam int ID_W      = 22;
   localparam int PERIOD_W  = 20;
   localparam int RUNTIME_W = 20;
   localparam int LOAD_W    = 10;
   localparam int STATUS_W  = 3;
   localparam int ORDER_W   = 32;
   localparam int PER_MILLE = 1000;
   localparam int PROD_W    = 30;
   localparam logic [LOAD_W-1:0] BOUND_RESET = LOAD_W'(693);

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER   = 2'd0,
      OP_YIELD      = 2'd1,
      OP_DEREGISTER = 2'd2,
      OP_TICK       = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK          = 3'd0,
      RS_OVER_BOUND  = 3'd1,
      RS_DUPLICATE   = 3'd2,
      RS_NOT_FOUND   = 3'd3,
      RS_TABLE_FULL  = 3'd4,
      RS_ZERO_PERIOD = 3'd5
   } status_code_type;

   typedef enum logic [1:0] {
      TS_READY    = 2'd0,
      TS_RUNNING  = 2'd1,
      TS_SLEEPING = 2'd2
   } task_state_type;

   typedef enum logic [1:0] {
      SCAN_FIND,
      SCAN_REG,
      SCAN_TICK,
      SCAN_DISP
   } scan_mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_REG_SCAN,
      S_FIND_SCAN,
      S_TICK_SCAN,
      S_DISP_SCAN,
      S_DISP_RUN,
      S_OUT
   } fsm_state_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic [LOAD_W-1:0]   load;
      logic [ORDER_W-1:0]  order;
   } main_entry_type;

   // controller to datapath
   typedef struct packed {
      logic            capture;
      logic            div_start;
      logic            scan_start;
      scan_mode_type   scan_mode;
      logic            reg_commit;
      logic            yield_commit;
      logic            dereg_commit;
      logic            disp_run;
      logic            disp_demote;
      logic            out_load;
      status_code_type code;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type op;
      logic       zero_period;
      logic       div_done;
      logic       over_bound;
      logic       scan_done;
      logic       dup;
      logic       free_found;
      logic       found;
      logic       released;
      logic       best_found;
      logic       cur_valid;
      logic       preempt;
   } dp_flag_type;

endpackage

// ===== src/rms_div.sv =====
// rms_div.sv: restoring divider, one quotient bit per cycle
// depends on rms_pkg
module rms_div import rms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output logic                done,
   output logic [PROD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W:0]   trial;
   logic [PERIOD_W:0]   diff;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[PERIOD_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[PERIOD_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/rms_datapath.sv =====
// rms_datapath.sv: task table memories, slot scan, divider and result register
// depends on rms_pkg and rms_div
module rms_datapath import rms_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_flag_type          flag,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [ID_W-1:0]      req_task_id,
   input  logic [PERIOD_W-1:0]  req_period_ms,
   input  logic [RUNTIME_W-1:0] req_runtime_ms,
   input  logic                 csr_wr_en,
   input  logic [LOAD_W-1:0]    csr_wr_data,
   output logic [STATUS_W-1:0]  out_status,
   output logic                 out_running_valid,
   output logic [ID_W-1:0]      out_running_id,
   output logic [LOAD_W-1:0]    out_total_load
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   // captured transaction
   opcode_type            op_ff;
   logic [ID_W-1:0]       id_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [PROD_W-1:0]     dividend_ff;
   logic [LOAD_W-1:0]     bound_ff;
   logic [LOAD_W-1:0]     total_ff, total_in;
   logic [ORDER_W-1:0]    order_ff;
   logic [MAX_TASKS-1:0]  valid_ff, valid_in;

   // table memories
   main_entry_type        mem_main [MAX_TASKS];
   logic [PERIOD_W-1:0]   mem_cd   [MAX_TASKS];
   task_state_type        mem_st   [MAX_TASKS];
   main_entry_type        rd_main_ff;
   logic [PERIOD_W-1:0]   rd_cd_ff;
   task_state_type        rd_st_ff;

   // scan control
   logic                  scan_busy_ff;
   logic [CW-1:0]         scan_addr_ff;
   logic                  rd_vld_ff;
   logic [IW-1:0]         rd_idx_ff;
   scan_mode_type         scan_mode_ff;
   logic                  scan_done_ff;

   // scan results
   logic                  found_ff, dup_ff, free_found_ff, released_ff, best_found_ff;
   logic [IW-1:0]         found_slot_ff, free_slot_ff, best_slot_ff;
   logic [LOAD_W-1:0]     found_load_ff;
   logic [PERIOD_W-1:0]   best_period_ff;
   logic [ORDER_W-1:0]    best_order_ff;
   logic [ID_W-1:0]       best_id_ff;

   // running task
   logic                  cur_valid_ff, cur_valid_in;
   logic [IW-1:0]         cur_slot_ff;
   logic [ID_W-1:0]       cur_id_ff;
   logic [PERIOD_W-1:0]   cur_period_ff;

   // result register
   logic [STATUS_W-1:0]   out_status_ff;
   logic                  out_run_valid_ff;
   logic [ID_W-1:0]       out_run_id_ff;
   logic [LOAD_W-1:0]     out_total_ff;

   logic                  div_done;
   logic [PROD_W-1:0]     quotient;
   logic                  slot_v;
   logic                  id_hit;
   logic                  tick_proc, tick_rel, better;
   logic                  st_we, cd_we;
   logic [IW-1:0]         st_waddr, cd_waddr;
   task_state_type        st_wdata;
   logic [PERIOD_W-1:0]   cd_wdata;
   logic                  cur_hit_found;

   rms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend_ff),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // capture of the transaction and the bound register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= opcode_type'(req_opcode);
         id_ff       <= req_task_id;
         period_ff   <= req_period_ms;
         dividend_ff <= PROD_W'(req_runtime_ms) * PROD_W'(PER_MILLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= BOUND_RESET;
      end else if (csr_wr_en) begin
         bound_ff <= csr_wr_data;
      end
   end

   // per-slot decode of the word just read
   always_comb begin
      slot_v    = rd_vld_ff && valid_ff[rd_idx_ff];
      id_hit    = slot_v && (rd_main_ff.id == id_ff);
      tick_proc = slot_v && (scan_mode_ff == SCAN_TICK);
      tick_rel  = tick_proc && (rd_cd_ff <= PERIOD_W'(1));
      better    = !best_found_ff || (rd_main_ff.period < best_period_ff) ||
                  ((rd_main_ff.period == best_period_ff) &&
                   (rd_main_ff.order < best_order_ff));
      cur_hit_found = cur_valid_ff && (cur_slot_ff == found_slot_ff);
   end

   // status memory write selection
   always_comb begin
      st_we    = 1'b1;
      st_waddr = rd_idx_ff;
      st_wdata = TS_READY;
      if (cmd.reg_commit) begin
         st_waddr = free_slot_ff;
         st_wdata = TS_SLEEPING;
      end else if (cmd.yield_commit) begin
         st_waddr = found_slot_ff;
         st_wdata = TS_SLEEPING;
      end else if (cmd.disp_run) begin
         st_waddr = best_slot_ff;
         st_wdata = TS_RUNNING;
      end else if (cmd.disp_demote) begin
         st_waddr = cur_slot_ff;
         st_wdata = TS_READY;
      end else begin
         st_we = tick_rel && !(cur_valid_ff && (cur_slot_ff == rd_idx_ff));
      end
   end

   // countdown memory write selection
   always_comb begin
      cd_we    = 1'b1;
      cd_waddr = rd_idx_ff;
      cd_wdata = rd_cd_ff - PERIOD_W'(1);
      if (cmd.reg_commit) begin
         cd_waddr = free_slot_ff;
         cd_wdata = period_ff;
      end else if (tick_rel) begin
         cd_wdata = rd_main_ff.period;
      end else begin
         cd_we = tick_proc;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.reg_commit) begin
         mem_main[free_slot_ff] <= '{id: id_ff, period: period_ff,
                                     load: quotient[LOAD_W-1:0], order: order_ff};
      end
      rd_main_ff <= mem_main[scan_addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cd_we) begin
         mem_cd[cd_waddr] <= cd_wdata;
      end
      rd_cd_ff <= mem_cd[scan_addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         mem_st[st_waddr] <= st_wdata;
      end
      rd_st_ff <= mem_st[scan_addr_ff[IW-1:0]];
   end

   // scan sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         scan_mode_ff <= SCAN_FIND;
         scan_done_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= scan_busy_ff;
         rd_idx_ff    <= scan_addr_ff[IW-1:0];
         scan_done_ff <= rd_vld_ff && (rd_idx_ff == IW'(MAX_TASKS - 1));
         if (cmd.scan_start) begin
            scan_busy_ff <= 1'b1;
            scan_addr_ff <= '0;
            scan_mode_ff <= cmd.scan_mode;
         end else if (scan_busy_ff) begin
            scan_addr_ff <= scan_addr_ff + CW'(1);
            if (scan_addr_ff == CW'(MAX_TASKS - 1)) begin
               scan_busy_ff <= 1'b0;
            end
         end
      end
   end

   // scan result flags
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         released_ff   <= 1'b0;
         best_found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         found_ff      <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         released_ff   <= 1'b0;
         best_found_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         case (scan_mode_ff)
            SCAN_FIND: begin
               if (id_hit && !found_ff) begin
                  found_ff <= 1'b1;
               end
            end
            SCAN_REG: begin
               if (id_hit) begin
                  dup_ff <= 1'b1;
               end
               if (!slot_v) begin
                  free_found_ff <= 1'b1;
               end
            end
            SCAN_TICK: begin
               if (tick_rel) begin
                  released_ff <= 1'b1;
               end
            end
            SCAN_DISP: begin
               if (slot_v && (rd_st_ff == TS_READY)) begin
                  best_found_ff <= 1'b1;
               end
            end
            default: begin
               found_ff <= found_ff;
            end
         endcase
      end
   end

   // scan result payload
   always_ff @(posedge clock) begin
      if (rd_vld_ff && (scan_mode_ff == SCAN_FIND) && id_hit && !found_ff) begin
         found_slot_ff <= rd_idx_ff;
         found_load_ff <= rd_main_ff.load;
      end
      if (rd_vld_ff && (scan_mode_ff == SCAN_REG) && !slot_v && !free_found_ff) begin
         free_slot_ff <= rd_idx_ff;
      end
      if (rd_vld_ff && (scan_mode_ff == SCAN_DISP) && slot_v &&
          (rd_st_ff == TS_READY) && better) begin
         best_slot_ff   <= rd_idx_ff;
         best_period_ff <= rd_main_ff.period;
         best_order_ff  <= rd_main_ff.order;
         best_id_ff     <= rd_main_ff.id;
      end
   end

   // table bookkeeping
   always_comb begin
      valid_in     = valid_ff;
      total_in     = total_ff;
      cur_valid_in = cur_valid_ff;
      if (cmd.reg_commit) begin
         valid_in[free_slot_ff] = 1'b1;
         total_in = total_ff + quotient[LOAD_W-1:0];
      end
      if (cmd.dereg_commit) begin
         valid_in[found_slot_ff] = 1'b0;
         total_in = total_ff - found_load_ff;
      end
      if ((cmd.dereg_commit || cmd.yield_commit) && cur_hit_found) begin
         cur_valid_in = 1'b0;
      end
      if (cmd.disp_run) begin
         cur_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         total_ff     <= '0;
         order_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_slot_ff  <= '0;
      end else begin
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         cur_valid_ff <= cur_valid_in;
         if (cmd.reg_commit) begin
            order_ff <= order_ff + ORDER_W'(1);
         end
         if (cmd.disp_run) begin
            cur_slot_ff <= best_slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.disp_run) begin
         cur_id_ff     <= best_id_ff;
         cur_period_ff <= best_period_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff    <= cmd.code;
         out_run_valid_ff <= cur_valid_ff;
         out_run_id_ff    <= cur_valid_ff ? cur_id_ff : '0;
         out_total_ff     <= total_ff;
      end
   end

   // status towards the controller
   always_comb begin
      flag.op          = op_ff;
      flag.zero_period = (period_ff == '0);
      flag.div_done    = div_done;
      flag.over_bound  = ({1'b0, quotient} + (PROD_W + 1)'(total_ff)) >
                         (PROD_W + 1)'(bound_ff);
      flag.scan_done   = scan_done_ff;
      flag.dup         = dup_ff;
      flag.free_found  = free_found_ff;
      flag.found       = found_ff;
      flag.released    = released_ff;
      flag.best_found  = best_found_ff;
      flag.cur_valid   = cur_valid_ff;
      flag.preempt     = best_period_ff < cur_period_ff;
   end

   assign out_status        = out_status_ff;
   assign out_running_valid = out_run_valid_ff;
   assign out_running_id    = out_run_id_ff;
   assign out_total_load    = out_total_ff;

endmodule

// ===== src/rms_ctrl.sv =====
// rms_ctrl.sv: command sequencer and handshake control of the scheduler
// depends on rms_pkg
module rms_ctrl import rms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_flag_type flag,
   output dp_cmd_type  cmd
);

   fsm_state_type   state_ff, state_in;
   status_code_type code_ff, code_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            out_free;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in = RS_OK;
            case (flag.op)
               OP_REGISTER: begin
                  if (flag.zero_period) begin
                     code_in  = RS_ZERO_PERIOD;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_DIV;
                  end
               end
               OP_YIELD, OP_DEREGISTER: state_in = S_FIND_SCAN;
               OP_TICK:                 state_in = S_TICK_SCAN;
               default:                 state_in = S_OUT;
            endcase
         end
         S_DIV: begin
            if (flag.div_done) begin
               if (flag.over_bound) begin
                  code_in  = RS_OVER_BOUND;
                  state_in = S_OUT;
               end else begin
                  state_in = S_REG_SCAN;
               end
            end
         end
         S_REG_SCAN: begin
            if (flag.scan_done) begin
               state_in = S_OUT;
               if (flag.dup) begin
                  code_in = RS_DUPLICATE;
               end else if (!flag.free_found) begin
                  code_in = RS_TABLE_FULL;
               end
            end
         end
         S_FIND_SCAN: begin
            if (flag.scan_done) begin
               if (!flag.found) begin
                  code_in  = RS_NOT_FOUND;
                  state_in = S_OUT;
               end else if (flag.op == OP_YIELD) begin
                  state_in = S_DISP_SCAN;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_TICK_SCAN: begin
            if (flag.scan_done) begin
               state_in = flag.released ? S_DISP_SCAN : S_OUT;
            end
         end
         S_DISP_SCAN: begin
            if (flag.scan_done) begin
               if (flag.best_found && flag.cur_valid && flag.preempt) begin
                  state_in = S_DISP_RUN;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_DISP_RUN: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.scan_mode = SCAN_FIND;
      cmd.code      = code_ff;
      case (state_ff)
         S_IDLE: cmd.capture = accept;
         S_DECODE: begin
            if (flag.op == OP_REGISTER) begin
               cmd.div_start = !flag.zero_period;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = (flag.op == OP_TICK) ? SCAN_TICK : SCAN_FIND;
            end
         end
         S_DIV: begin
            if (flag.div_done && !flag.over_bound) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_REG;
            end
         end
         S_REG_SCAN: begin
            cmd.reg_commit = flag.scan_done && !flag.dup && flag.free_found;
         end
         S_FIND_SCAN: begin
            if (flag.scan_done && flag.found) begin
               if (flag.op == OP_YIELD) begin
                  cmd.yield_commit = 1'b1;
                  cmd.scan_start   = 1'b1;
                  cmd.scan_mode    = SCAN_DISP;
               end else begin
                  cmd.dereg_commit = 1'b1;
               end
            end
         end
         S_TICK_SCAN: begin
            if (flag.scan_done && flag.released) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_DISP;
            end
         end
         S_DISP_SCAN: begin
            if (flag.scan_done && flag.best_found) begin
               cmd.disp_run    = !flag.cur_valid;
               cmd.disp_demote = flag.cur_valid && flag.preempt;
            end
         end
         S_DISP_RUN: cmd.disp_run = 1'b1;
         S_OUT:      cmd.out_load = out_free;
         default:    cmd.code = code_ff;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= RS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/rate_monotonic_task_scheduler.sv =====
// rate_monotonic_task_scheduler.sv: top level of the rate monotonic task scheduler
// depends on rms_pkg, rms_ctrl and rms_datapath
//
// One command transaction enters on the req_ channel (register, yield,
// deregister or millisecond tick) and gives exactly one transaction on the
// rsp_ channel: a status code, the running task and the total admitted load.
// The csr_ port writes the load bound; write it only while the block is idle.
// The block works on one transaction at a time; req_stall is high from
// acceptance until the result has been placed in the output register.
// Each pass over the table reads one slot a cycle from the slot memories.
// From acceptance to the loading of the result: a register runs the 30-step
// serial divider and then one pass (no pass when over the bound, and neither
// divider nor pass for a zero period). A yield of a known task and a releasing
// tick take two passes (find or count down, then dispatch), and a further run
// step when a running task is preempted. Deregister and a tick with no release
// take one pass. A finished result waits in the output register while the
// receiver stalls, and the next transaction can be accepted in the cycle
// after that load; its own result waits until the earlier one is taken.
// Synchronous reset empties the table, clears the running task and sets the
// bound to 693 per mille.
module rate_monotonic_task_scheduler import rms_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_opcode,
   input  logic [ID_W-1:0]      req_task_id,
   input  logic [PERIOD_W-1:0]  req_period_ms,
   input  logic [RUNTIME_W-1:0] req_runtime_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_running_valid,
   output logic [ID_W-1:0]      rsp_running_id,
   output logic [LOAD_W-1:0]    rsp_total_load_per_mille,
   input  logic                 csr_wr_en,
   input  logic [LOAD_W-1:0]    csr_wr_data
);

   dp_cmd_type  cmd;
   dp_flag_type flag;

   // sequencer
   rms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flag      (flag),
      .cmd       (cmd)
   );

   // table and arithmetic
   rms_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flag              (flag),
      .req_opcode        (req_opcode),
      .req_task_id       (req_task_id),
      .req_period_ms     (req_period_ms),
      .req_runtime_ms    (req_runtime_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .out_status        (rsp_status),
      .out_running_valid (rsp_running_valid),
      .out_running_id    (rsp_running_id),
      .out_total_load    (rsp_total_load_per_mille)
   );

endmodule

// ===== src/rms_checker.sv =====
// rms_checker.sv: port-level assertions for the scheduler, bound to the top level
// depends on rate_monotonic_task_scheduler_defines.svh
`include "rate_monotonic_task_scheduler_defines.svh"

module rms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic        rsp_running_valid,
   input logic [21:0] rsp_running_id
);

   // a held result keeps its payload
   `RMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_running_id), "stalled result changed")

   // no running task reads as id zero
   `RMS_ASSERT_NOW(a_idle_id, clock, reset, rsp_valid && !rsp_running_valid, rsp_running_id == 22'd0, "running id not zero while idle")

   // the block is busy right after taking a transaction
   `RMS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted twice in a row")

   // reset leaves no result and an open input
   `RMS_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && !req_stall, "bad state after reset")

endmodule

bind rate_monotonic_task_scheduler rms_checker u_rms_checker (.*);
